// ===== rtl/ssro_pkg.sv =====
// shared types, constants and segment lookup for the sample readout
package ssro_pkg;

  localparam int SAMPLE_W = 10;
  localparam int GAIN_W   = 18;
  localparam int OFFSET_W = 28;
  localparam int PROD_W   = 28;
  localparam int VAL_W    = 14;
  localparam int DIGIT_W  = 4;
  localparam int CFG_W    = 28;
  localparam int NUM_DIGITS = 4;
  localparam int POS_W    = 2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 18'd169014;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 28'd113764761;
  localparam logic [PROD_W-1:0]   MAX_SHOWN    = 28'd9999;

  // register index codes
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  // reciprocal constants: q = (v * RECIP) >> SHIFT, exact for v up to 9999
  localparam logic [12:0] RECIP10   = 13'd6554;
  localparam logic [12:0] RECIP100  = 13'd5243;
  localparam logic [13:0] RECIP1000 = 14'd8389;

  localparam logic [DIGIT_W-1:0] DASH_CODE = 4'd10;
  localparam logic [POS_W-1:0]   POINT_POS = 2'd2;
  localparam logic [POS_W-1:0]   LAST_POS  = 2'd3;

  typedef logic [7:0] seg_t;
  typedef seg_t [NUM_DIGITS-1:0] seg_group_t;

  // active-low pattern, bit7 decimal point, bit0 segment a
  function automatic seg_t seg_byte(input logic [DIGIT_W-1:0] code, input logic point);
    seg_t pat;
    case (code)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h40;
    endcase
    if (point) begin
      pat = pat | 8'h80;
    end
    return ~pat;
  endfunction

endpackage

// ===== rtl/sample_to_seven_segment_readout_top.sv =====
// top level: scale a converter sample and send it as four seven-segment bytes
//
// Each accepted sample becomes four active-low segment bytes, units first and
// thousands last with tlast set; the hundreds byte carries the decimal point.
// A sample passes four register stages (input, product, offset and shift,
// digit quotients) before its bytes enter the output serializer. The
// serializer sends one byte per cycle while m_axis_tready is high, which
// bounds the sustained sample rate; samples are taken in consecutive cycles
// while the stages ahead have room. gain and offset may be written only
// while no sample is in flight.
module sample_to_seven_segment_readout_top
  import ssro_pkg::*;
#(
  parameter int FRACTION_SHIFT = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [9:0] adc_sample
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] segment_byte
  output logic             m_axis_tlast    // latch_strobe
);

  logic [GAIN_W-1:0]   gain;
  logic [OFFSET_W-1:0] offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain   <= GAIN_RESET;
      offset <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_GAIN:   gain   <= cfg_data[GAIN_W-1:0];
        REG_OFFSET: offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic va, vb, vc, vd;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic ser_ready;

  assign rdy_d = !vd || ser_ready;
  assign rdy_c = !vc || rdy_d;
  assign rdy_b = !vb || rdy_c;
  assign rdy_a = !va || rdy_b;
  assign s_axis_tready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (rdy_a) va <= s_axis_tvalid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
    end
  end

  // stage a: sample
  logic [SAMPLE_W-1:0] sample;
  always_ff @(posedge clk) begin
    if (rdy_a) sample <= s_axis_tdata[SAMPLE_W-1:0];
  end

  // stage b: product
  logic [PROD_W-1:0] prod;
  always_ff @(posedge clk) begin
    if (rdy_b) prod <= PROD_W'(sample) * PROD_W'(gain);
  end

  // stage c: remove offset, drop fraction, clamp
  logic [PROD_W:0]   diff;
  logic              neg;
  logic [PROD_W-1:0] shifted;
  logic              over_c;
  logic [VAL_W-1:0]  val_c;

  always_comb begin
    diff    = {1'b0, prod} - {1'b0, offset};
    neg     = diff[PROD_W];
    shifted = diff[PROD_W-1:0] >> FRACTION_SHIFT;
    over_c  = !neg && (shifted > MAX_SHOWN);
    val_c   = (neg || over_c) ? '0 : shifted[VAL_W-1:0];
  end

  logic [VAL_W-1:0] val;
  logic             over;
  always_ff @(posedge clk) begin
    if (rdy_c) begin
      val  <= val_c;
      over <= over_c;
    end
  end

  // stage d: quotients by reciprocal multiply
  logic [26:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;
  assign p10   = 27'(val) * 27'(RECIP10);
  assign p100  = 27'(val) * 27'(RECIP100);
  assign p1000 = 28'(val) * 28'(RECIP1000);

  logic [VAL_W-1:0] val_d;
  logic             over_d;
  logic [10:0]      q1;
  logic [7:0]       q2;
  logic [4:0]       q3;
  always_ff @(posedge clk) begin
    if (rdy_d) begin
      val_d  <= val;
      over_d <= over;
      q1     <= p10[26:16];
      q2     <= p100[26:19];
      q3     <= p1000[27:23];
    end
  end

  // digits and segment patterns
  logic [VAL_W-1:0]             r0;
  logic [10:0]                  r1;
  logic [7:0]                   r2;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] code;
  seg_group_t                   group;

  always_comb begin
    r0 = val_d - {q1, 3'b000} - VAL_W'({q1, 1'b0});
    r1 = q1 - {q2[7:0], 3'b000} - {2'b00, q2, 1'b0};
    r2 = q2 - {q3, 3'b000} - {2'b00, q3, 1'b0};
    code[0] = r0[DIGIT_W-1:0];
    code[1] = r1[DIGIT_W-1:0];
    code[2] = r2[DIGIT_W-1:0];
    code[3] = q3[DIGIT_W-1:0];
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (over_d) code[k] = DASH_CODE;
      group[k] = seg_byte(code[k], POS_W'(k) == POINT_POS);
    end
  end

  ssro_serializer u_ser (
    .clk           (clk),
    .rst           (rst),
    .load_valid    (vd),
    .load_ready    (ser_ready),
    .load_bytes    (group),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/ssro_serializer.sv =====
// sends a group of four segment bytes, one per cycle while m_axis_tready is high, last one flagged
module ssro_serializer
  import ssro_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  output logic       load_ready,
  input  seg_group_t load_bytes,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast
);

  seg_group_t       bytes;
  logic [POS_W-1:0] pos;
  logic             busy;
  logic             take;
  logic             load;

  assign take       = busy && m_axis_tready;
  assign load_ready = !busy || (m_axis_tready && pos == LAST_POS);
  assign load       = load_valid && load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else begin
      if (take) begin
        pos <= pos + 1'b1;
        if (pos == LAST_POS) begin
          busy <= 1'b0;
        end
      end
      if (load) begin
        busy <= 1'b1;
        pos  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= load_bytes;
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = bytes[pos];
  assign m_axis_tlast  = (pos == LAST_POS);

endmodule

// ===== rtl/ssro_checker.sv =====
// port-level checks for the sample readout, bound to the top level
module ssro_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic [1:0] pos;
  logic [3:0] pending;
  logic       in_req;
  logic       out_req;
  logic       group_done;

  assign in_req     = s_axis_tvalid && s_axis_tready;
  assign out_req    = m_axis_tvalid && m_axis_tready;
  assign group_done = out_req && pos == 2'd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pending <= '0;
    end else begin
      if (out_req) pos <= pos + 1'b1;
      pending <= pending + {3'b000, in_req} - {3'b000, group_done};
    end
  end

  a_last_on_fourth: assert property (@(posedge clk) disable iff (rst)
    out_req |-> (m_axis_tlast == (pos == 2'd3)))
    else $error("tlast not on the fourth byte of a group");

  a_point_on_hundreds: assert property (@(posedge clk) disable iff (rst)
    out_req |-> (m_axis_tdata[7] == (pos != 2'd2)))
    else $error("decimal point lit on the wrong byte");

  a_no_invented_bytes: assert property (@(posedge clk) disable iff (rst)
    out_req |-> (pending != 4'd0))
    else $error("output byte without a pending request");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind sample_to_seven_segment_readout_top ssro_checker u_ssro_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
